/* rtl/core/fcw_pkg.sv */
package fcw_pkg;

	// allocation table geometry
	localparam int TABLE_ENTRIES = 4096;
	localparam int ADDR_W        = $clog2(TABLE_ENTRIES);

	localparam int CLUSTER_W = 16;
	localparam int OFFSET_W  = 40;
	localparam logic [CLUSTER_W-1:0] END_MARK = 16'hFFF8;

	// root directory entries are 32 bytes
	localparam int DIR_ENTRY_SHIFT = 5;
	localparam int ROOT_BYTES_W    = 16 + DIR_ENTRY_SHIFT;

	// item modes
	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_START = 2'd1;
	localparam logic [1:0] MODE_STEP  = 2'd2;

	// configuration register indexes
	localparam logic [2:0] CFG_BPS  = 3'd0;
	localparam logic [2:0] CFG_SPC  = 3'd1;
	localparam logic [2:0] CFG_RSV  = 3'd2;
	localparam logic [2:0] CFG_FATS = 3'd3;
	localparam logic [2:0] CFG_SPF  = 3'd4;
	localparam logic [2:0] CFG_ROOT = 3'd5;

	// region sequencer phases
	localparam int RG_CNT_W     = 5;
	localparam int RG_MUL       = 0;
	localparam int RG_ADD       = 1;
	localparam int RG_SCALE     = 2;
	localparam int RG_DIV_FIRST = 3;
	localparam int RG_DIV_LAST  = RG_DIV_FIRST + ROOT_BYTES_W - 1;
	localparam int RG_SUM       = RG_DIV_LAST + 1;
	localparam int RG_DONE      = RG_SUM + 1;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] index;
		logic [15:0] value;
	} item_t;

	typedef struct packed {
		logic [15:0]         cluster;
		logic [OFFSET_W-1:0] byte_offset;
		logic                chain_end;
		logic                fault;
	} result_t;

	typedef struct packed {
		logic [12:0] bytes_per_sector;
		logic [7:0]  sectors_per_cluster;
		logic [15:0] reserved_sectors;
		logic [7:0]  fat_copies;
		logic [15:0] sectors_per_fat;
		logic [15:0] root_entries;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SCALE,
		ST_EMIT
	} fsm_t;

	function automatic logic is_end(input logic [CLUSTER_W-1:0] c);
		return c >= END_MARK;
	endfunction

	function automatic logic out_of_table(input logic [CLUSTER_W-1:0] c);
		return {1'b0, c} >= (CLUSTER_W+1)'(TABLE_ENTRIES);
	endfunction

	function automatic logic cluster_bad(input logic [CLUSTER_W-1:0] c);
		return (c < 16'd2) || out_of_table(c);
	endfunction

endpackage

/* rtl/core/fcw_fat_mem.sv */
module fcw_fat_mem (
	input  logic                      clk,
	input  logic                      we,
	input  logic [fcw_pkg::ADDR_W-1:0] waddr,
	input  logic [15:0]               wdata,
	input  logic                      re,
	input  logic [fcw_pkg::ADDR_W-1:0] raddr,
	output logic [15:0]               rdata
);
	import fcw_pkg::*;

	logic [15:0] mem [TABLE_ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/core/fcw_region_calc.sv */
module fcw_region_calc (
	input  logic                        clk,
	input  logic                        arst_n,
	input  fcw_pkg::cfg_t               cfg,
	input  logic                        recalc,
	output logic [fcw_pkg::OFFSET_W-1:0] region,
	output logic                        ready
);
	import fcw_pkg::*;

	logic [RG_CNT_W-1:0]     cnt_q;
	logic [23:0]             prod_q;
	logic [24:0]             sum_q;
	logic [37:0]             base_q;
	logic [12:0]             rem_q;
	logic [OFFSET_W-1:0]     region_q;

	logic [ROOT_BYTES_W-1:0] root_bytes;
	logic [RG_CNT_W-1:0]     bit_idx;
	logic [13:0]             trial;
	logic [13:0]             trial_sub;
	logic [ROOT_BYTES_W:0]   root_round;

	assign root_bytes = {cfg.root_entries, {DIR_ENTRY_SHIFT{1'b0}}};
	assign bit_idx    = RG_CNT_W'(RG_DIV_LAST) - cnt_q;
	assign trial      = {rem_q, root_bytes[bit_idx]};
	assign trial_sub  = trial - {1'b0, cfg.bytes_per_sector};

	// root bytes rounded up to a whole sector (zero if the sector size is zero)
	always_comb begin
		if (cfg.bytes_per_sector == '0) begin
			root_round = '0;
		end else if (rem_q == '0) begin
			root_round = {1'b0, root_bytes};
		end else begin
			root_round = {1'b0, root_bytes} + (ROOT_BYTES_W+1)'(cfg.bytes_per_sector)
				- (ROOT_BYTES_W+1)'(rem_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (recalc) begin
			cnt_q <= '0;
		end else if (cnt_q != RG_CNT_W'(RG_DONE)) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_q == RG_CNT_W'(RG_MUL)) begin
			prod_q <= 24'(cfg.fat_copies) * 24'(cfg.sectors_per_fat);
			rem_q  <= '0;
		end else if (cnt_q == RG_CNT_W'(RG_ADD)) begin
			sum_q <= 25'(cfg.reserved_sectors) + 25'(prod_q);
		end else if (cnt_q == RG_CNT_W'(RG_SCALE)) begin
			base_q <= 38'(sum_q) * 38'(cfg.bytes_per_sector);
		end else if (cnt_q <= RG_CNT_W'(RG_DIV_LAST)) begin
			// one remainder bit a cycle
			if (trial >= {1'b0, cfg.bytes_per_sector}) begin
				rem_q <= trial_sub[12:0];
			end else begin
				rem_q <= trial[12:0];
			end
		end else if (cnt_q == RG_CNT_W'(RG_SUM)) begin
			region_q <= OFFSET_W'(base_q) + OFFSET_W'(root_round);
		end
	end

	assign region = region_q;
	assign ready  = (cnt_q == RG_CNT_W'(RG_DONE)) && !recalc;

endmodule

/* rtl/core/fat16_cluster_chain_walker.sv */
// fat16 allocation table with a cluster chain follower
//
// item channel (item_valid/item_ready/item): one transfer is one command.
//   write entry stores item.value at table entry item.index if it is in the table,
//   start chain loads the chain position, step chain reports the current cluster
//   and its data offset, then moves to that cluster's table entry if it is live
// result channel (result_valid/result_ready/result): exactly one result per item
// cfg port: cfg_we writes cfg_wdata to register cfg_index at once; user must write only while idle, unchecked
//
// timing: write and start pass straight to the output register, a step first goes
//   through the table read and two multiply stages, then the offset add; one item
//   is in flight at a time, so a new item is taken only once the last result is loaded
// the data region base, which needs a remainder by the sector size, is worked
//   out by a sequencer after reset and after every cfg write; item_ready stays
//   low meanwhile
// reset: chain position 0xffff (no chain), registers at their defaults, table
//   contents undefined until written
// a stalled result holds in the output register; the finished item waits in
//   its last state and no new item is taken until the result register frees
module fat16_cluster_chain_walker (
	input  logic            clk,
	input  logic            arst_n,

	input  logic            item_valid,
	output logic            item_ready,
	input  fcw_pkg::item_t   item,

	output logic            result_valid,
	input  logic            result_ready,
	output fcw_pkg::result_t result,

	input  logic            cfg_we,
	input  logic [2:0]      cfg_index,
	input  logic [15:0]     cfg_wdata
);
	import fcw_pkg::*;

	// configuration registers
	cfg_t cfg_q;

	// control
	fsm_t state_q, state_d;
	logic [15:0] pos_q;
	logic        result_valid_q;

	// item in flight
	logic [15:0]         cur_q;
	logic                norm_q;
	logic [15:0]         cluster_q;
	logic                end_q;
	logic                fault_q;
	logic [23:0]         m1_q;
	logic [36:0]         m2_q;
	result_t             result_q;

	// result fields of the item being offered
	logic [15:0]         cluster_d;
	logic                end_d;
	logic                fault_d;

	// handshakes and strobes
	logic item_xfer;
	logic res_load;
	logic mem_re;
	logic mem_we;
	logic rg_ready;
	logic [OFFSET_W-1:0] region;
	logic [15:0] rdata;

	logic step_go;
	logic [15:0] cur_m2;
	logic [OFFSET_W-1:0] offset;

	assign item_xfer = item_valid && item_ready;

	// a step that really walks: position is a live in-table cluster
	assign step_go = (item.mode == MODE_STEP) && !is_end(pos_q) && !cluster_bad(pos_q);
	assign mem_we  = item_xfer && (item.mode == MODE_WRITE) && !out_of_table(item.index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bytes_per_sector    <= 13'd512;
			cfg_q.sectors_per_cluster <= 8'd1;
			cfg_q.reserved_sectors    <= 16'd1;
			cfg_q.fat_copies          <= 8'd2;
			cfg_q.sectors_per_fat     <= 16'd1;
			cfg_q.root_entries        <= 16'd512;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BPS:  cfg_q.bytes_per_sector    <= cfg_wdata[12:0];
				CFG_SPC:  cfg_q.sectors_per_cluster <= cfg_wdata[7:0];
				CFG_RSV:  cfg_q.reserved_sectors    <= cfg_wdata;
				CFG_FATS: cfg_q.fat_copies          <= cfg_wdata[7:0];
				CFG_SPF:  cfg_q.sectors_per_fat     <= cfg_wdata;
				CFG_ROOT: cfg_q.root_entries        <= cfg_wdata;
				default: ;
			endcase
		end
	end

	fcw_region_calc u_region (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.recalc (cfg_we),
		.region (region),
		.ready  (rg_ready)
	);

	fcw_fat_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (item.index[ADDR_W-1:0]),
		.wdata (item.value),
		.re    (mem_re),
		.raddr (pos_q[ADDR_W-1:0]),
		.rdata (rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_xfer) begin
					state_d = step_go ? ST_READ : ST_EMIT;
				end
			end
			ST_READ:  state_d = ST_SCALE;
			ST_SCALE: state_d = ST_EMIT;
			ST_EMIT: begin
				if (res_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		item_ready = 1'b0;
		mem_re     = 1'b0;
		res_load   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = rg_ready;
				mem_re     = item_valid && rg_ready && step_go;
			end
			ST_EMIT: res_load = !result_valid_q || result_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// chain position: loaded by start, and by a walking step once the entry is read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 16'hFFFF;
		end else if (item_xfer && (item.mode == MODE_START)) begin
			pos_q <= item.index;
		end else if (state_q == ST_READ) begin
			pos_q <= rdata;
		end
	end

	// result fields as known at the transfer
	always_comb begin
		cluster_d = '0;
		end_d     = 1'b0;
		fault_d   = 1'b0;
		case (item.mode)
			MODE_WRITE: fault_d = out_of_table(item.index);
			MODE_START: begin
				end_d   = is_end(item.index);
				fault_d = !is_end(item.index) && cluster_bad(item.index);
			end
			MODE_STEP: begin
				if (is_end(pos_q)) begin
					end_d = 1'b1;
				end else begin
					cluster_d = pos_q;
					fault_d   = cluster_bad(pos_q);
				end
			end
			default: ;
		endcase
	end

	// result fields settled at the transfer, end flag patched after the read
	always_ff @(posedge clk) begin
		if (item_xfer) begin
			cur_q     <= pos_q;
			norm_q    <= step_go;
			cluster_q <= cluster_d;
			end_q     <= end_d;
			fault_q   <= fault_d;
		end else if (state_q == ST_READ) begin
			end_q <= is_end(rdata);
		end
	end

	// (cluster - 2) * sectors per cluster, then * bytes per sector
	assign cur_m2 = cur_q - 16'd2;

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			m1_q <= 24'(cur_m2) * 24'(cfg_q.sectors_per_cluster);
		end
		if (state_q == ST_SCALE) begin
			m2_q <= 37'(m1_q) * 37'(cfg_q.bytes_per_sector);
		end
	end

	assign offset = norm_q ? (region + OFFSET_W'(m2_q)) : '0;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (res_load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			result_q.cluster     <= cluster_q;
			result_q.byte_offset <= offset;
			result_q.chain_end   <= end_q;
			result_q.fault       <= fault_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// one item in flight
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_xfer |=> !item_ready)
		else $error("item taken while another is in flight");

	// base recompute blocks items right after a register write
	a_cfg_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !item_ready)
		else $error("item accepted during region recompute");

	// a table read is always followed by the scale stage
	a_read_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |=> (state_q == ST_SCALE))
		else $error("step sequence broken after table read");

	// end of chain and fault are exclusive
	a_end_fault: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.chain_end && result.fault))
		else $error("result flags both end of chain and fault");

endmodule
